@@ rtl/core/mutex_lock_with_wait_queue_assert.svh @@
// Assertion macros shared by the mutex block.
`ifndef MUTEX_LOCK_WITH_WAIT_QUEUE_ASSERT_SVH
`define MUTEX_LOCK_WITH_WAIT_QUEUE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define MTXQ_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define MTXQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/mtxq_pkg.sv @@
// Shared types and codes for the mutex with wait queue.
package mtxq_pkg;

  // Request operation codes
  typedef enum logic [1:0] {
    OP_LOCK    = 2'd0,
    OP_TRYLOCK = 2'd1,
    OP_UNLOCK  = 2'd2
  } op_e_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_QUEUED    = 3'd1,
    ST_BUSY      = 3'd2,
    ST_DEADLOCK  = 3'd3,
    ST_NOT_OWNER = 3'd4,
    ST_FULL      = 3'd5,
    ST_SATURATED = 3'd6
  } status_e_t;

  // Mutex type register codes
  typedef enum logic [1:0] {
    MT_NORMAL     = 2'd0,
    MT_RECURSIVE  = 2'd1,
    MT_ERRORCHECK = 2'd2
  } mtype_e_t;

  localparam int unsigned MTYPE_W = 2;

endpackage

@@ rtl/core/mtxq_if.sv @@
// Valid/ready channel interfaces for mutex requests and results.
interface mtxq_req_if #(
  parameter int unsigned ID_BITS = 6
);
  logic                   valid;
  logic                   ready;
  mtxq_pkg::op_e_t        operation;
  logic [ID_BITS-1:0]     requester_id;

  modport source (output valid, output operation, output requester_id, input ready);
  modport sink   (input valid, input operation, input requester_id, output ready);
endinterface

interface mtxq_rsp_if #(
  parameter int unsigned ID_BITS    = 6,
  parameter int unsigned DEPTH_BITS = 8
);
  logic                    valid;
  logic                    ready;
  mtxq_pkg::status_e_t     status;
  logic                    handoff_valid;
  logic [ID_BITS-1:0]      handoff_id;
  logic [DEPTH_BITS-1:0]   recursion_depth;

  modport source (output valid, output status, output handoff_valid, output handoff_id,
                  output recursion_depth, input ready);
  modport sink   (input valid, input status, input handoff_valid, input handoff_id,
                  input recursion_depth, output ready);
endinterface

@@ rtl/core/mutex_lock_with_wait_queue.sv @@
// Path: an accepted request loads the input reg, which then loads the result reg when it fires.
// Throughput: one request per cycle while the result is not stalled; the waiter queue head is prefetched from its RAM.
// A stalled result holds the result reg; the input reg takes the next item meanwhile only if it is empty.
// Reset (rst, synchronous, active high): mutex free, queue empty, type normal.
// Waiter queue storage is not cleared; only pushed entries are ever handed off.
module mutex_lock_with_wait_queue #(
  parameter int unsigned ID_BITS     = 6,
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned DEPTH_BITS  = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [mtxq_pkg::MTYPE_W-1:0]   cfg_wdata,
  mtxq_req_if.sink                       request,
  mtxq_rsp_if.source                     result
);

  `include "mutex_lock_with_wait_queue_assert.svh"

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [DEPTH_BITS-1:0] DEPTH_ONE = DEPTH_BITS'(1);

  // Configuration register
  mtxq_pkg::mtype_e_t mutex_type;

  always_ff @(posedge clk) begin
    if (rst) begin
      mutex_type <= mtxq_pkg::MT_NORMAL;
    end else if (cfg_we) begin
      mutex_type <= mtxq_pkg::mtype_e_t'(cfg_wdata);
    end
  end

  // Input register
  logic                 s_valid;
  mtxq_pkg::op_e_t      s_op;
  logic [ID_BITS-1:0]   s_id;
  logic                 s_fire;

  // Result register
  logic                    o_valid;
  mtxq_pkg::status_e_t     o_status;
  logic                    o_hvalid;
  logic [ID_BITS-1:0]      o_hid;
  logic [DEPTH_BITS-1:0]   o_depth;

  assign s_fire        = s_valid && (!o_valid || result.ready);
  assign request.ready = !s_valid || s_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (request.ready) begin
      s_valid <= request.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (request.valid && request.ready) begin
      s_op <= request.operation;
      s_id <= request.requester_id;
    end
  end

  // Mutex state
  logic                    owned;
  logic [ID_BITS-1:0]      owner_id;
  logic [DEPTH_BITS-1:0]   lock_depth;
  logic [PTR_W-1:0]        fifo_head;
  logic [PTR_W-1:0]        fifo_tail;
  logic [CNT_W-1:0]        fifo_count;
  logic [ID_BITS-1:0]      head_word;

  logic                    owned_next;
  logic [ID_BITS-1:0]      owner_id_next;
  logic [DEPTH_BITS-1:0]   lock_depth_next;
  mtxq_pkg::status_e_t     status_next;
  logic                    hvalid_next;
  logic [ID_BITS-1:0]      hid_next;
  logic                    push;
  logic                    pop;
  logic                    is_owner;

  assign is_owner = owned && (owner_id == s_id);

  // Request decode against the current state
  always_comb begin
    owned_next      = owned;
    owner_id_next   = owner_id;
    lock_depth_next = lock_depth;
    status_next     = mtxq_pkg::ST_OK;
    hvalid_next     = 1'b0;
    hid_next        = '0;
    push            = 1'b0;
    pop             = 1'b0;
    unique case (s_op)
      mtxq_pkg::OP_LOCK, mtxq_pkg::OP_TRYLOCK: begin
        priority if (!owned) begin
          owned_next      = 1'b1;
          owner_id_next   = s_id;
          lock_depth_next = DEPTH_ONE;
        end else if (mutex_type == mtxq_pkg::MT_RECURSIVE && is_owner) begin
          if (lock_depth == '1) begin
            status_next = mtxq_pkg::ST_SATURATED;
          end else begin
            lock_depth_next = lock_depth + DEPTH_ONE;
          end
        end else if (mutex_type == mtxq_pkg::MT_ERRORCHECK && is_owner) begin
          status_next = mtxq_pkg::ST_DEADLOCK;
        end else if (s_op == mtxq_pkg::OP_TRYLOCK) begin
          status_next = mtxq_pkg::ST_BUSY;
        end else if (fifo_count == CNT_FULL) begin
          status_next = mtxq_pkg::ST_FULL;
        end else begin
          push        = 1'b1;
          status_next = mtxq_pkg::ST_QUEUED;
        end
      end
      mtxq_pkg::OP_UNLOCK: begin
        priority if (!is_owner) begin
          status_next = mtxq_pkg::ST_NOT_OWNER;
        end else if (mutex_type == mtxq_pkg::MT_RECURSIVE && lock_depth > DEPTH_ONE) begin
          lock_depth_next = lock_depth - DEPTH_ONE;
        end else if (fifo_count != '0) begin
          pop             = 1'b1;
          owner_id_next   = head_word;
          lock_depth_next = DEPTH_ONE;
          hvalid_next     = 1'b1;
          hid_next        = head_word;
        end else begin
          owned_next      = 1'b0;
          owner_id_next   = '0;
          lock_depth_next = '0;
        end
      end
      default: begin
        // unused operation code: no change
      end
    endcase
  end

  // Queue pointer advance
  logic                push_fire;
  logic                pop_fire;
  logic [PTR_W-1:0]    head_addr_next;
  logic [PTR_W-1:0]    tail_addr_next;

  assign push_fire      = s_fire && push;
  assign pop_fire       = s_fire && pop;
  assign head_addr_next = pop_fire ? ((fifo_head == PTR_LAST) ? '0 : fifo_head + PTR_W'(1))
                                   : fifo_head;
  assign tail_addr_next = push_fire ? ((fifo_tail == PTR_LAST) ? '0 : fifo_tail + PTR_W'(1))
                                    : fifo_tail;

  // State update
  always_ff @(posedge clk) begin
    if (rst) begin
      owned      <= 1'b0;
      owner_id   <= '0;
      lock_depth <= '0;
      fifo_head  <= '0;
      fifo_tail  <= '0;
      fifo_count <= '0;
    end else begin
      if (s_fire) begin
        owned      <= owned_next;
        owner_id   <= owner_id_next;
        lock_depth <= lock_depth_next;
      end
      fifo_head <= head_addr_next;
      fifo_tail <= tail_addr_next;
      if (push_fire) begin
        fifo_count <= fifo_count + CNT_W'(1);
      end else if (pop_fire) begin
        fifo_count <= fifo_count - CNT_W'(1);
      end
    end
  end

  // Waiter RAM: one write port at the tail, registered read of the next head
  logic [ID_BITS-1:0] waiters [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (push_fire) begin
      waiters[fifo_tail] <= s_id;
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire && (fifo_tail == head_addr_next)) begin
      head_word <= s_id;
    end else begin
      head_word <= waiters[head_addr_next];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s_fire) begin
      o_valid <= 1'b1;
    end else if (result.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      o_status <= status_next;
      o_hvalid <= hvalid_next;
      o_hid    <= hid_next;
      o_depth  <= lock_depth_next;
    end
  end

  assign result.valid           = o_valid;
  assign result.status          = o_status;
  assign result.handoff_valid   = o_hvalid;
  assign result.handoff_id      = o_hid;
  assign result.recursion_depth = o_depth;

  // Checks
  `MTXQ_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, fifo_count <= CNT_FULL, "queue count overflow")
  `MTXQ_ASSERT_NOW(a_depth_owned, clk, rst, 1'b1, owned == (lock_depth != '0), "depth and owned disagree")
  `MTXQ_ASSERT_NOW(a_free_empty, clk, rst, !owned, fifo_count == '0 && owner_id == '0, "free mutex with waiters")
  `MTXQ_ASSERT_NOW(a_handoff_ok, clk, rst, o_valid && o_hvalid, o_status == mtxq_pkg::ST_OK && o_depth == DEPTH_ONE, "bad handoff result")
  `MTXQ_ASSERT_NEXT(a_push_count, clk, rst, push_fire, fifo_count == $past(fifo_count) + CNT_W'(1), "push lost")

endmodule
